// ===== sv/ocms_pkg.sv =====
package ocms_pkg;

  localparam int TOTAL_BITS = 38;

  localparam logic [3:0] OP_ADD        = 4'd0;
  localparam logic [3:0] OP_REMOVE     = 4'd1;
  localparam logic [3:0] OP_REMOVE_ALL = 4'd2;
  localparam logic [3:0] OP_POP_MIN    = 4'd3;
  localparam logic [3:0] OP_POP_MAX    = 4'd4;
  localparam logic [3:0] OP_COUNT      = 4'd5;
  localparam logic [3:0] OP_GE         = 4'd6;
  localparam logic [3:0] OP_GT         = 4'd7;
  localparam logic [3:0] OP_LE         = 4'd8;
  localparam logic [3:0] OP_LT         = 4'd9;
  localparam logic [3:0] OP_PEEK_MIN   = 4'd10;
  localparam logic [3:0] OP_PEEK_MAX   = 4'd11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] key;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [31:0]           result_key;
    logic [31:0]           result_count;
    logic [TOTAL_BITS-1:0] total_items;
    logic [6:0]            duplicate_keys;
  } rsp_t;

endpackage

// ===== sv/ocms_table.sv =====
module ocms_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ocms_pkg::req_t req,
  output ocms_pkg::rsp_t rsp
);

  localparam int UW = $clog2(CAPACITY + 1);
  localparam int SW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam int XW = ((COUNT_BITS > ocms_pkg::TOTAL_BITS) ? COUNT_BITS
                                                           : ocms_pkg::TOTAL_BITS) + 1;
  localparam int TB = ocms_pkg::TOTAL_BITS;

  logic [KEY_BITS-1:0]   keys   [CAPACITY];
  logic [COUNT_BITS-1:0] counts [CAPACITY];
  logic [UW-1:0]         used;
  logic [TB-1:0]         total;
  logic [UW-1:0]         dup;

  logic [KEY_BITS-1:0]   k;
  logic [CAPACITY-1:0]   row_valid, lt, le, eq;
  logic [CAPACITY-1:0]   lt_up, le_up, lt_dn, le_dn, rv_dn;
  logic [CAPACITY-1:0]   ge_oh, gt_oh, le_oh, lt_oh, min_oh, max_oh, ins_pt;
  logic [CAPACITY-1:0]   sel, shdn;
  logic [KEY_BITS-1:0]   sk;
  logic [COUNT_BITS-1:0] sc;
  logic                  any, full;

  logic [SW-1:0]         amt_x, sc_x, sum_x, take_x, cmax_x;
  logic [COUNT_BITS-1:0] add_nc, sub_nc, nc;
  logic [1:0]            status;
  logic                  found, do_insert, do_delete, do_cwrite, stat_update;
  logic [KEY_BITS-1:0]   rkey;
  logic [COUNT_BITS-1:0] rcnt;

  logic [XW-1:0]         tot_x, oc_x, t1_x, nc_x, tmax_x, t2_x;
  logic [TB-1:0]         total_next;
  logic [UW-1:0]         d1, dup_next;

  always_comb begin
    k = KEY_BITS'(req.key);
    for (int i = 0; i < CAPACITY; i++) begin
      row_valid[i] = UW'(i) < used;
      lt[i]        = row_valid[i] && (keys[i] < k);
      le[i]        = row_valid[i] && (keys[i] <= k);
      eq[i]        = row_valid[i] && (keys[i] == k);
    end
    lt_up  = {lt[CAPACITY-2:0], 1'b1};
    le_up  = {le[CAPACITY-2:0], 1'b1};
    lt_dn  = {1'b0, lt[CAPACITY-1:1]};
    le_dn  = {1'b0, le[CAPACITY-1:1]};
    rv_dn  = {1'b0, row_valid[CAPACITY-1:1]};
    ge_oh  = row_valid & ~lt & lt_up;
    gt_oh  = row_valid & ~le & le_up;
    le_oh  = le & ~le_dn;
    lt_oh  = lt & ~lt_dn;
    min_oh = {{(CAPACITY-1){1'b0}}, row_valid[0]};
    max_oh = row_valid & ~rv_dn;
    ins_pt = ~lt & lt_up;
  end

  always_comb begin
    unique case (req.opcode) inside
      ocms_pkg::OP_ADD, ocms_pkg::OP_REMOVE, ocms_pkg::OP_REMOVE_ALL,
      ocms_pkg::OP_COUNT:                              sel = eq;
      ocms_pkg::OP_POP_MIN, ocms_pkg::OP_PEEK_MIN:     sel = min_oh;
      ocms_pkg::OP_POP_MAX, ocms_pkg::OP_PEEK_MAX:     sel = max_oh;
      ocms_pkg::OP_GE:                                 sel = ge_oh;
      ocms_pkg::OP_GT:                                 sel = gt_oh;
      ocms_pkg::OP_LE:                                 sel = le_oh;
      ocms_pkg::OP_LT:                                 sel = lt_oh;
      default:                                         sel = '0;
    endcase
  end

  always_comb begin
    sk = '0;
    sc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sk = sk | ({KEY_BITS{sel[i]}} & keys[i]);
      sc = sc | ({COUNT_BITS{sel[i]}} & counts[i]);
    end
    any  = |sel;
    full = used == UW'(CAPACITY);
  end

  always_comb begin
    cmax_x = SW'({COUNT_BITS{1'b1}});
    amt_x  = SW'(req.amount);
    sc_x   = SW'(sc);
    sum_x  = sc_x + amt_x;
    add_nc = (sum_x > cmax_x) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(sum_x);
    take_x = (req.opcode == ocms_pkg::OP_REMOVE) ? amt_x : SW'(1);
    sub_nc = (take_x < sc_x) ? COUNT_BITS'(sc_x - take_x) : '0;
  end

  always_comb begin
    status    = ocms_pkg::ST_OK;
    found     = 1'b0;
    rkey      = '0;
    rcnt      = '0;
    nc        = sc;
    do_insert = 1'b0;
    do_delete = 1'b0;
    do_cwrite = 1'b0;
    shdn      = ~lt;
    unique case (req.opcode) inside
      ocms_pkg::OP_ADD: begin
        if (any) begin
          found     = 1'b1;
          rkey      = sk;
          nc        = add_nc;
          rcnt      = add_nc;
          do_cwrite = req.amount != '0;
        end else if (req.amount != '0) begin
          if (full) begin
            status = ocms_pkg::ST_FULL;
          end else begin
            found     = 1'b1;
            rkey      = k;
            nc        = add_nc;
            rcnt      = add_nc;
            do_insert = 1'b1;
          end
        end
      end
      ocms_pkg::OP_REMOVE, ocms_pkg::OP_POP_MIN, ocms_pkg::OP_POP_MAX: begin
        if (!any) begin
          status = ocms_pkg::ST_EMPTY;
        end else begin
          found     = 1'b1;
          rkey      = sk;
          nc        = sub_nc;
          rcnt      = sub_nc;
          do_cwrite = 1'b1;
          do_delete = sub_nc == '0;
        end
        if (req.opcode == ocms_pkg::OP_POP_MIN) begin
          shdn = '1;
        end else if (req.opcode == ocms_pkg::OP_POP_MAX) begin
          shdn = '0;
        end
      end
      ocms_pkg::OP_REMOVE_ALL: begin
        if (!any) begin
          status = ocms_pkg::ST_EMPTY;
        end else begin
          found     = 1'b1;
          rkey      = sk;
          nc        = '0;
          do_delete = 1'b1;
        end
      end
      ocms_pkg::OP_COUNT, ocms_pkg::OP_GE, ocms_pkg::OP_GT, ocms_pkg::OP_LE,
      ocms_pkg::OP_LT, ocms_pkg::OP_PEEK_MIN, ocms_pkg::OP_PEEK_MAX: begin
        if (any) begin
          found = 1'b1;
          rkey  = sk;
          rcnt  = sc;
        end else begin
          status = ocms_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    stat_update = do_insert | do_delete | do_cwrite;
  end

  always_comb begin
    tot_x      = XW'(total);
    oc_x       = XW'(sc);
    t1_x       = (tot_x >= oc_x) ? (tot_x - oc_x) : '0;
    nc_x       = XW'(nc);
    tmax_x     = XW'({TB{1'b1}});
    t2_x       = ((tmax_x - t1_x) < nc_x) ? tmax_x : (t1_x + nc_x);
    total_next = TB'(t2_x);
    d1         = ((sc >= COUNT_BITS'(2)) && (dup != '0)) ? (dup - UW'(1)) : dup;
    dup_next   = (nc >= COUNT_BITS'(2)) ? (d1 + UW'(1)) : d1;
  end

  always_comb begin
    rsp.status         = status;
    rsp.found          = found;
    rsp.result_key     = 32'(rkey);
    rsp.result_count   = 32'(rcnt);
    rsp.total_items    = stat_update ? total_next : total;
    rsp.duplicate_keys = 7'(stat_update ? dup_next : dup);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
      dup   <= '0;
    end else if (en) begin
      if (stat_update) begin
        total <= total_next;
        dup   <= dup_next;
      end
      if (do_insert) begin
        used <= used + UW'(1);
      end else if (do_delete) begin
        used <= used - UW'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [COUNT_BITS-1:0] prev_cnt, next_cnt;

    if (i == 0) begin : g_first
      assign prev_key = k;
      assign prev_cnt = nc;
    end else begin : g_mid
      assign prev_key = keys[i-1];
      assign prev_cnt = counts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = keys[i];
      assign next_cnt = counts[i];
    end else begin : g_inner
      assign next_key = keys[i+1];
      assign next_cnt = counts[i+1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (do_insert) begin
          if (!lt[i]) begin
            keys[i]   <= ins_pt[i] ? k  : prev_key;
            counts[i] <= ins_pt[i] ? nc : prev_cnt;
          end
        end else if (do_delete) begin
          if (shdn[i]) begin
            keys[i]   <= next_key;
            counts[i] <= next_cnt;
          end
        end else if (do_cwrite && sel[i]) begin
          counts[i] <= nc;
        end
      end
    end
  end

endmodule

// ===== sv/ordered_counted_multiset_top.sv =====
// Ordered counted multiset: a key-sorted table of distinct keys with counts.
// Request channel (req_valid/req_ready/req) carries one word per operation:
// opcode, key and amount. Response channel (rsp_valid/rsp_ready/rsp) returns
// exactly one word per request, in order: status, found, key, count, the
// running total of items and the number of keys held two or more times.
// A request waits in the request register; its response enters the response
// register when the response side is free. Throughput: one request per cycle
// while responses are taken; every key of the table is compared in parallel
// in the single stage between the request and response registers, so each
// operation, inserts and removals that shift the table included, completes in it.
// Reset empties the table and clears the totals and both valid flags; the
// stored keys and counts are not cleared and are read only once written.
// When the receiver holds rsp_ready low, the response word holds, the
// request register fills, and req_ready drops until the response is taken.
module ordered_counted_multiset_top #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ocms_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ocms_pkg::rsp_t rsp
);

  logic           stage_valid;
  ocms_pkg::req_t stage_req;
  ocms_pkg::rsp_t table_rsp;
  logic           advance;

  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (req_ready) begin
        stage_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_req <= req;
    end
    if (advance) begin
      rsp <= table_rsp;
    end
  end

  ocms_table #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (stage_req),
    .rsp (table_rsp)
  );

endmodule

// ===== sv/ocms_checker.sv =====
module ocms_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input ocms_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input ocms_pkg::rsp_t rsp
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request word changed while waiting");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.result_key == '0 && rsp.result_count == '0)
    else $error("miss carries a key or count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ocms_pkg::ST_OK)
    else $error("found entry with error status");

  a_dup_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.duplicate_keys != '0 |-> rsp.total_items >= 2)
    else $error("duplicate keys with fewer than two items");

endmodule

bind ordered_counted_multiset_top ocms_checker u_checker (.*);

// ===== bench/tb_ordered_counted_multiset_top.sv =====
module tb_ordered_counted_multiset_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 64;
  localparam logic [3:0]  OP_SPARE_LO = 4'd12;
  localparam logic [3:0]  OP_SPARE_HI = 4'd15;
  localparam logic [63:0] COUNT_MAX   = 64'hFFFF_FFFF;
  localparam logic [63:0] TOTAL_MAX   = (64'd1 << ocms_pkg::TOTAL_BITS) - 64'd1;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  ocms_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  ocms_pkg::rsp_t rsp;

  logic [31:0] tbl_key [TABLE_DEPTH];
  logic [63:0] tbl_cnt [TABLE_DEPTH];
  int          n_used    = 0;
  logic [63:0] sum_items = '0;
  int          n_dups    = 0;

  ocms_pkg::rsp_t pending_rsp[$];
  logic [31:0]    key_pool[$];
  int             mismatch_count = 0;
  bit             steady = 1'b0;

  ordered_counted_multiset_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int first_not_below(logic [31:0] k);
    int i;
    i = 0;
    while (i < n_used && tbl_key[i] < k) i++;
    return i;
  endfunction

  function automatic int first_above(logic [31:0] k);
    int i;
    i = 0;
    while (i < n_used && tbl_key[i] <= k) i++;
    return i;
  endfunction

  function automatic void set_count(int idx, logic [63:0] nc);
    logic [63:0] oc;
    logic [63:0] t;
    oc = tbl_cnt[idx];
    t = (sum_items >= oc) ? sum_items - oc : 64'd0;
    if (oc >= 2 && n_dups > 0) n_dups--;
    if (nc >= 2) n_dups++;
    sum_items = (TOTAL_MAX - t < nc) ? TOTAL_MAX : t + nc;
    tbl_cnt[idx] = nc;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i < n_used - 1; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_cnt[i] = tbl_cnt[i + 1];
    end
    n_used--;
  endfunction

  function automatic ocms_pkg::rsp_t predict_response(ocms_pkg::req_t w);
    ocms_pkg::rsp_t r;
    logic [63:0]    amt;
    logic [63:0]    c;
    logic [63:0]    nc;
    int             lb;
    int             ub;
    int             idx;
    bit             hit;
    bit             sel;
    r   = '0;
    sel = 1'b0;
    idx = 0;
    amt = {32'd0, w.amount};
    lb  = first_not_below(w.key);
    ub  = first_above(w.key);
    hit = (lb < n_used) && (tbl_key[lb] == w.key);
    case (w.opcode)
      ocms_pkg::OP_ADD: begin
        if (hit) begin
          c = tbl_cnt[lb];
          if (amt != 0) set_count(lb, (COUNT_MAX - c < amt) ? COUNT_MAX : c + amt);
          idx = lb;
          sel = 1'b1;
        end else if (amt != 0) begin
          if (n_used >= TABLE_DEPTH) begin
            r.status = ocms_pkg::ST_FULL;
          end else begin
            for (int i = n_used; i > lb; i--) begin
              tbl_key[i] = tbl_key[i - 1];
              tbl_cnt[i] = tbl_cnt[i - 1];
            end
            tbl_key[lb] = w.key;
            tbl_cnt[lb] = '0;
            n_used++;
            set_count(lb, amt);
            idx = lb;
            sel = 1'b1;
          end
        end
      end
      ocms_pkg::OP_REMOVE, ocms_pkg::OP_POP_MIN, ocms_pkg::OP_POP_MAX: begin
        if (w.opcode == ocms_pkg::OP_REMOVE) begin
          if (!hit) r.status = ocms_pkg::ST_EMPTY;
          else idx = lb;
        end else if (n_used == 0) begin
          r.status = ocms_pkg::ST_EMPTY;
        end else begin
          idx = (w.opcode == ocms_pkg::OP_POP_MIN) ? 0 : n_used - 1;
          amt = 64'd1;
        end
        if (r.status == ocms_pkg::ST_OK) begin
          c  = tbl_cnt[idx];
          nc = c - ((amt < c) ? amt : c);
          r.found        = 1'b1;
          r.result_key   = tbl_key[idx];
          r.result_count = nc[31:0];
          set_count(idx, nc);
          if (nc == 0) drop_entry(idx);
        end
      end
      ocms_pkg::OP_REMOVE_ALL: begin
        if (!hit) begin
          r.status = ocms_pkg::ST_EMPTY;
        end else begin
          set_count(lb, '0);
          drop_entry(lb);
          r.found      = 1'b1;
          r.result_key = w.key;
        end
      end
      ocms_pkg::OP_COUNT: begin
        if (hit) begin
          idx = lb;
          sel = 1'b1;
        end else begin
          r.status = ocms_pkg::ST_EMPTY;
        end
      end
      ocms_pkg::OP_GE, ocms_pkg::OP_GT: begin
        idx = (w.opcode == ocms_pkg::OP_GE) ? lb : ub;
        if (idx < n_used) sel = 1'b1;
        else r.status = ocms_pkg::ST_EMPTY;
      end
      ocms_pkg::OP_LE, ocms_pkg::OP_LT: begin
        idx = ((w.opcode == ocms_pkg::OP_LE) ? ub : lb) - 1;
        if (idx >= 0) sel = 1'b1;
        else r.status = ocms_pkg::ST_EMPTY;
      end
      ocms_pkg::OP_PEEK_MIN, ocms_pkg::OP_PEEK_MAX: begin
        if (n_used == 0) begin
          r.status = ocms_pkg::ST_EMPTY;
        end else begin
          idx = (w.opcode == ocms_pkg::OP_PEEK_MIN) ? 0 : n_used - 1;
          sel = 1'b1;
        end
      end
      default: ;
    endcase
    if (sel) begin
      r.found        = 1'b1;
      r.result_key   = tbl_key[idx];
      r.result_count = tbl_cnt[idx][31:0];
    end
    r.total_items    = sum_items[ocms_pkg::TOTAL_BITS-1:0];
    r.duplicate_keys = n_dups[6:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(logic [3:0] op, logic [31:0] k, logic [31:0] amount);
    ocms_pkg::req_t w;
    int             gap;
    w.opcode = op;
    w.key    = k;
    w.amount = amount;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(predict_response(w));
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  initial begin : rsp_side
    int run;
    int hold;
    forever begin
      rsp_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : rsp_check
    ocms_pkg::rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch("unexpected word", 64'd0, 64'(rsp.result_key));
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(rsp.status));
          if (rsp.found !== want.found)
            flag_mismatch("found", 64'(want.found), 64'(rsp.found));
          if (rsp.result_key !== want.result_key)
            flag_mismatch("result_key", 64'(want.result_key), 64'(rsp.result_key));
          if (rsp.result_count !== want.result_count)
            flag_mismatch("result_count", 64'(want.result_count), 64'(rsp.result_count));
          if (rsp.total_items !== want.total_items)
            flag_mismatch("total_items", 64'(want.total_items), 64'(rsp.total_items));
          if (rsp.duplicate_keys !== want.duplicate_keys)
            flag_mismatch("duplicate_keys", 64'(want.duplicate_keys),
                          64'(rsp.duplicate_keys));
        end
      end
    end
  end

  task automatic test_empty_table();
    send_word(ocms_pkg::OP_PEEK_MIN, $urandom, $urandom);
    send_word(ocms_pkg::OP_POP_MAX, $urandom, $urandom);
    send_word(ocms_pkg::OP_COUNT, 32'd5, 32'd1);
    send_word(ocms_pkg::OP_GE, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_LT, 32'hFFFF_FFFF, 32'd0);
    send_word(ocms_pkg::OP_REMOVE, 32'd9, 32'd1);
    send_word(ocms_pkg::OP_REMOVE_ALL, 32'd9, 32'd0);
    send_word(ocms_pkg::OP_ADD, 32'd9, 32'd0);
  endtask

  task automatic test_edge_values();
    send_word(ocms_pkg::OP_ADD, 32'd0, 32'd1);
    send_word(ocms_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ocms_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd5);
    send_word(ocms_pkg::OP_ADD, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_REMOVE, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_REMOVE, 32'd1, 32'd0);
    send_word(ocms_pkg::OP_ADD, 32'd0, 32'd1);
    send_word(ocms_pkg::OP_ADD, 32'h8000_0000, 32'd3);
    send_word(ocms_pkg::OP_GE, 32'd1, 32'd0);
    send_word(ocms_pkg::OP_GT, 32'h8000_0000, 32'd0);
    send_word(ocms_pkg::OP_GT, 32'hFFFF_FFFF, 32'd0);
    send_word(ocms_pkg::OP_LE, 32'h7FFF_FFFF, 32'd0);
    send_word(ocms_pkg::OP_LT, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_LE, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_REMOVE, 32'h8000_0000, 32'd10);
    send_word(ocms_pkg::OP_COUNT, 32'h8000_0000, 32'd0);
    send_word(ocms_pkg::OP_REMOVE_ALL, 32'hFFFF_FFFF, 32'd0);
    send_word(ocms_pkg::OP_POP_MAX, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_POP_MIN, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_PEEK_MAX, 32'd0, 32'd0);
  endtask

  task automatic test_fill_to_capacity();
    logic [31:0] fresh;
    int          pos;
    while (n_used < TABLE_DEPTH) send_word(ocms_pkg::OP_ADD, $urandom, $urandom_range(1, 4));
    do begin
      fresh = $urandom;
      pos   = first_not_below(fresh);
    end while (pos < n_used && tbl_key[pos] == fresh);
    send_word(ocms_pkg::OP_ADD, fresh, 32'd7);
    send_word(ocms_pkg::OP_ADD, fresh, 32'd0);
    send_word(ocms_pkg::OP_ADD, tbl_key[5], 32'd2);
    send_word(ocms_pkg::OP_PEEK_MAX, 32'd0, 32'd0);
    send_word(ocms_pkg::OP_LE, fresh, 32'd0);
    wait_drain();
  endtask

  function automatic logic [31:0] pick_key();
    int          r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 10) return $urandom;
    if (r < 15) return k + 32'd1;
    if (r < 20) return k - 32'd1;
    return k;
  endfunction

  function automatic logic [31:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 70) return $urandom_range(1, 3);
    if (r < 85) return $urandom_range(1, 1000);
    if (r < 95) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic logic [3:0] pick_op(int add_share);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_share) return ocms_pkg::OP_ADD;
    r = $urandom_range(0, 99);
    if (r < 20) return ocms_pkg::OP_REMOVE;
    if (r < 28) return ocms_pkg::OP_REMOVE_ALL;
    if (r < 36) return ocms_pkg::OP_POP_MIN;
    if (r < 44) return ocms_pkg::OP_POP_MAX;
    if (r < 54) return ocms_pkg::OP_COUNT;
    if (r < 61) return ocms_pkg::OP_GE;
    if (r < 68) return ocms_pkg::OP_GT;
    if (r < 75) return ocms_pkg::OP_LE;
    if (r < 82) return ocms_pkg::OP_LT;
    if (r < 88) return ocms_pkg::OP_PEEK_MIN;
    if (r < 94) return ocms_pkg::OP_PEEK_MAX;
    return 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic test_random_ops(int n_items, int pool_size, int add_share);
    key_pool.delete();
    key_pool.push_back(32'd0);
    key_pool.push_back(32'hFFFF_FFFF);
    while (key_pool.size() < pool_size) key_pool.push_back($urandom);
    for (int i = 0; i < n_items; i++) begin
      steady = (i >= n_items / 4) && (i < n_items / 2);
      if (i == n_items / 2) wait_drain();
      send_word(pick_op(add_share), pick_key(), pick_amount());
    end
    steady = 1'b0;
  endtask

  task automatic test_drain_table();
    while (n_used > 0) begin
      if ($urandom_range(0, 1) == 0)
        send_word($urandom_range(0, 1) ? ocms_pkg::OP_POP_MIN : ocms_pkg::OP_POP_MAX,
                  $urandom, $urandom);
      else
        send_word(ocms_pkg::OP_REMOVE_ALL, tbl_key[$urandom_range(0, n_used - 1)], $urandom);
    end
    send_word(ocms_pkg::OP_POP_MIN, $urandom, $urandom);
    send_word(ocms_pkg::OP_GT, 32'd0, $urandom);
    send_word(ocms_pkg::OP_LE, 32'hFFFF_FFFF, $urandom);
  endtask

  initial begin : main
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_edge_values();
    test_fill_to_capacity();
    test_random_ops(150, 20, 35);
    test_random_ops(150, 72, 55);
    test_drain_table();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
